/* hdl/lrtp_pkg.sv */
// ----------------------------------------------------------------------------
// lrtp_pkg
// Types and constants shared by the LR table parser engine modules.
// ----------------------------------------------------------------------------
package lrtp_pkg;

   localparam int KIND_W   = 2;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 4;
   localparam int CODE_W   = 3;
   localparam int TGT_W    = 6;
   localparam int RIDX_W   = 5;
   localparam int HEAD_W   = 4;
   localparam int LEN_W    = 4;
   localparam int TOK_W    = 4;

   localparam int EV_W     = 2;
   localparam int RULE_W   = 5;
   localparam int STATE_W  = 6;
   localparam int DEPTH_W  = 7;
   localparam int CAUSE_W  = 3;

   localparam int ENTRY_W  = CODE_W + TGT_W;
   localparam int RSTORE_W = HEAD_W + LEN_W;

   localparam int RED_W = 6;
   localparam logic [RED_W-1:0] RED_LIMIT = 6'd63;

   localparam int REQ_ROW_LSB   = 0;
   localparam int REQ_COL_LSB   = REQ_ROW_LSB + ROW_W;
   localparam int REQ_CODE_LSB  = REQ_COL_LSB + COL_W;
   localparam int REQ_TGT_LSB   = REQ_CODE_LSB + CODE_W;
   localparam int REQ_RIDX_LSB  = REQ_TGT_LSB + TGT_W;
   localparam int REQ_HEAD_LSB  = REQ_RIDX_LSB + RIDX_W;
   localparam int REQ_LEN_LSB   = REQ_HEAD_LSB + HEAD_W;
   localparam int REQ_TOK_LSB   = REQ_LEN_LSB + LEN_W;
   localparam int REQ_FIELDS_W  = REQ_TOK_LSB + TOK_W;
   localparam int REQ_DATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam int RSP_RULE_LSB  = 0;
   localparam int RSP_STATE_LSB = RSP_RULE_LSB + RULE_W;
   localparam int RSP_DEPTH_LSB = RSP_STATE_LSB + STATE_W;
   localparam int RSP_CAUSE_LSB = RSP_DEPTH_LSB + DEPTH_W;
   localparam int RSP_FIELDS_W  = RSP_CAUSE_LSB + CAUSE_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENTRY = 2'd0,
      KIND_RULE  = 2'd1,
      KIND_START = 2'd2,
      KIND_TOKEN = 2'd3
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_EMPTY  = 3'd0,
      CODE_SHIFT  = 3'd1,
      CODE_REDUCE = 3'd2,
      CODE_ACCEPT = 3'd3,
      CODE_GOTO   = 3'd4
   } code_type;

   typedef enum logic [EV_W-1:0] {
      EV_SHIFT  = 2'd0,
      EV_REDUCE = 2'd1,
      EV_ACCEPT = 2'd2,
      EV_ERROR  = 2'd3
   } ev_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE      = 3'd0,
      CAUSE_EMPTY     = 3'd1,
      CAUSE_OVERFLOW  = 3'd2,
      CAUSE_UNDERFLOW = 3'd3,
      CAUSE_LIMIT     = 3'd4
   } cause_type;

   typedef enum logic [1:0] {
      PS_RUNNING  = 2'd0,
      PS_ACCEPTED = 2'd1,
      PS_FAILED   = 2'd2
   } pstat_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_ACT_RD = 3'd1,
      ST_ACT    = 3'd2,
      ST_RULE   = 3'd3,
      ST_UNDER  = 3'd4,
      ST_GOTO   = 3'd5
   } fsm_type;

   typedef struct packed {
      kind_type            kind;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    column;
      logic [CODE_W-1:0]   entry_code;
      logic [TGT_W-1:0]    entry_target;
      logic [RIDX_W-1:0]   rule_index;
      logic [HEAD_W-1:0]   rule_head;
      logic [LEN_W-1:0]    rule_length;
      logic [TOK_W-1:0]    token;
   } req_type;

   typedef struct packed {
      logic      take;
      logic      act_rd;
      logic      rule_rd;
      logic      under_rd;
      logic      goto_rd;
      logic      shift;
      logic      accept;
      logic      reduce;
      logic      fail;
      cause_type cause;
   } cmd_type;

   typedef struct packed {
      logic     running;
      code_type act_code;
      logic     act_oob;
      logic     tgt_bad;
      logic     red_limit;
      logic     stack_full;
      logic     len_under;
      logic     grow_full;
      logic     goto_ok;
      logic     out_free;
   } stat_type;

endpackage

/* hdl/lrtp_ctrl.sv */
// ----------------------------------------------------------------------------
// lrtp_ctrl
// Parse sequencer: steps each token through table, rule, stack and goto reads.
// ----------------------------------------------------------------------------
module lrtp_ctrl
   import lrtp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  kind_type req_kind,
   input  stat_type stat,
   output cmd_type  cmd
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_ACT_RD: begin
            cmd.act_rd = 1'b1;
         end
         ST_ACT: begin
            if (stat.act_oob) begin
               cmd.fail  = stat.out_free;
               cmd.cause = CAUSE_EMPTY;
            end else begin
               unique case (stat.act_code)
                  CODE_SHIFT: begin
                     if (stat.stack_full) begin
                        cmd.fail  = stat.out_free;
                        cmd.cause = CAUSE_OVERFLOW;
                     end else begin
                        cmd.shift = stat.out_free;
                     end
                  end
                  CODE_ACCEPT: begin
                     cmd.accept = stat.out_free;
                  end
                  CODE_REDUCE: begin
                     priority if (stat.tgt_bad) begin
                        cmd.fail  = stat.out_free;
                        cmd.cause = CAUSE_EMPTY;
                     end else if (stat.red_limit) begin
                        cmd.fail  = stat.out_free;
                        cmd.cause = CAUSE_LIMIT;
                     end else begin
                        cmd.rule_rd = 1'b1;
                     end
                  end
                  default: begin
                     cmd.fail  = stat.out_free;
                     cmd.cause = CAUSE_EMPTY;
                  end
               endcase
            end
         end
         ST_RULE: begin
            priority if (stat.len_under) begin
               cmd.fail  = stat.out_free;
               cmd.cause = CAUSE_UNDERFLOW;
            end else if (stat.grow_full) begin
               cmd.fail  = stat.out_free;
               cmd.cause = CAUSE_OVERFLOW;
            end else begin
               cmd.under_rd = 1'b1;
            end
         end
         ST_UNDER: begin
            cmd.goto_rd = 1'b1;
         end
         ST_GOTO: begin
            if (stat.goto_ok) begin
               cmd.reduce = stat.out_free;
            end else begin
               cmd.fail  = stat.out_free;
               cmd.cause = CAUSE_UNDERFLOW;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take && req_kind == KIND_TOKEN && stat.running) begin
               state_in = ST_ACT_RD;
            end
         end
         ST_ACT_RD: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            priority if (cmd.fail || cmd.shift || cmd.accept) begin
               state_in = ST_IDLE;
            end else if (cmd.rule_rd) begin
               state_in = ST_RULE;
            end else begin
               state_in = ST_ACT;
            end
         end
         ST_RULE: begin
            priority if (cmd.fail) begin
               state_in = ST_IDLE;
            end else if (cmd.under_rd) begin
               state_in = ST_UNDER;
            end else begin
               state_in = ST_RULE;
            end
         end
         ST_UNDER: begin
            state_in = ST_GOTO;
         end
         ST_GOTO: begin
            priority if (cmd.fail) begin
               state_in = ST_IDLE;
            end else if (cmd.reduce) begin
               state_in = ST_ACT_RD;
            end else begin
               state_in = ST_GOTO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/lrtp_dpath.sv */
// ----------------------------------------------------------------------------
// lrtp_dpath
// Action/goto table, rule store, state stack and the registered result beat.
// ----------------------------------------------------------------------------
module lrtp_dpath
   import lrtp_pkg::*;
#(
   parameter int STATES      = 64,
   parameter int SYMBOLS     = 16,
   parameter int RULES       = 32,
   parameter int STACK_DEPTH = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [EV_W-1:0]       rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int TBL_DEPTH = STATES * SYMBOLS;
   localparam int AW        = $clog2(TBL_DEPTH);
   localparam int RW        = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int SW        = $clog2(STACK_DEPTH);
   localparam int DW        = $clog2(STACK_DEPTH + 1);

   function automatic logic [AW-1:0] tbl_addr(input logic [STATE_W-1:0] st,
                                              input logic [COL_W-1:0]   col);
      return AW'(st) * AW'(SYMBOLS) + AW'(col);
   endfunction

   logic [ENTRY_W-1:0]  tbl_mem [TBL_DEPTH];
   logic [RSTORE_W-1:0] rule_mem [RULES];
   logic [STATE_W-1:0]  stk_mem [STACK_DEPTH];

   logic [ENTRY_W-1:0]  act_q_ff;
   logic [RSTORE_W-1:0] rule_q_ff;
   logic [STATE_W-1:0]  stk_q_ff;
   logic [TOK_W-1:0]    tok_ff;
   logic [TGT_W-1:0]    tgt_ff;
   logic [DW-1:0]       nd_ff;
   logic                goto_oob_ff;

   logic [RED_W-1:0]    red_cnt_ff, red_cnt_in;
   logic [STATE_W-1:0]  top_ff, top_in;
   logic [DW-1:0]       depth_ff, depth_in;
   pstat_type           status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   ev_type              rsp_user_ff, rsp_user_in;
   logic                rsp_last_ff, rsp_last_in;

   code_type            act_code;
   logic [TGT_W-1:0]    act_tgt;
   logic [HEAD_W-1:0]   rule_head;
   logic [LEN_W-1:0]    rule_len;
   logic [DW-1:0]       nd_calc;
   logic [DW-1:0]       nd_m1;
   logic [STATE_W-1:0]  under;
   logic [AW-1:0]       rd_addr;
   logic                tbl_wr, rule_wr, emit;
   cause_type           cause_out;
   logic [RULE_W-1:0]   rule_out;

   assign act_code  = code_type'(act_q_ff[ENTRY_W-1:TGT_W]);
   assign act_tgt   = act_q_ff[TGT_W-1:0];
   assign rule_head = rule_q_ff[RSTORE_W-1:LEN_W];
   assign rule_len  = rule_q_ff[LEN_W-1:0];
   assign nd_calc   = depth_ff - DW'(rule_len);
   assign nd_m1     = nd_calc - DW'(1);
   assign under     = (nd_ff == DW'(1)) ? '0 : stk_q_ff;
   assign rd_addr   = cmd.act_rd ? tbl_addr(top_ff, tok_ff) : tbl_addr(under, rule_head);
   assign emit      = cmd.shift | cmd.accept | cmd.fail | cmd.reduce;

   assign tbl_wr  = cmd.take && req.kind == KIND_ENTRY &&
                    int'(req.row) < STATES && int'(req.column) < SYMBOLS;
   assign rule_wr = cmd.take && req.kind == KIND_RULE && int'(req.rule_index) < RULES;

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         tbl_mem[tbl_addr(req.row, req.column)] <= {req.entry_code, req.entry_target};
      end
      if (cmd.act_rd || cmd.goto_rd) begin
         act_q_ff <= tbl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rule_wr) begin
         rule_mem[RW'(req.rule_index)] <= {req.rule_head, req.rule_length};
      end
      if (cmd.rule_rd) begin
         rule_q_ff <= rule_mem[RW'(act_tgt)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         stk_mem[depth_ff[SW-1:0]] <= act_tgt;
      end else if (cmd.reduce) begin
         stk_mem[nd_ff[SW-1:0]] <= act_tgt;
      end
      if (cmd.under_rd) begin
         stk_q_ff <= stk_mem[nd_m1[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req.kind == KIND_TOKEN) begin
         tok_ff <= req.token;
      end
      if (cmd.rule_rd) begin
         tgt_ff <= act_tgt;
      end
      if (cmd.under_rd) begin
         nd_ff <= nd_calc;
      end
      if (cmd.goto_rd) begin
         goto_oob_ff <= int'(under) >= STATES || int'(rule_head) >= SYMBOLS;
      end
   end

   always_comb begin
      depth_in   = depth_ff;
      top_in     = top_ff;
      status_in  = status_ff;
      red_cnt_in = red_cnt_ff;
      priority if (cmd.take) begin
         if (req.kind == KIND_START) begin
            depth_in  = DW'(1);
            top_in    = '0;
            status_in = PS_RUNNING;
         end
         if (req.kind == KIND_TOKEN) begin
            red_cnt_in = '0;
         end
      end else if (cmd.shift) begin
         depth_in = depth_ff + DW'(1);
         top_in   = act_tgt;
      end else if (cmd.reduce) begin
         depth_in   = nd_ff + DW'(1);
         top_in     = act_tgt;
         red_cnt_in = red_cnt_ff + RED_W'(1);
      end else if (cmd.accept) begin
         status_in = PS_ACCEPTED;
      end else if (cmd.fail) begin
         status_in = PS_FAILED;
      end
   end

   always_comb begin
      priority if (cmd.fail) begin
         rsp_user_in = EV_ERROR;
      end else if (cmd.accept) begin
         rsp_user_in = EV_ACCEPT;
      end else if (cmd.reduce) begin
         rsp_user_in = EV_REDUCE;
      end else begin
         rsp_user_in = EV_SHIFT;
      end
      cause_out    = cmd.fail ? cmd.cause : CAUSE_NONE;
      rule_out     = cmd.reduce ? RULE_W'(tgt_ff) : '0;
      rsp_last_in  = !cmd.reduce;
      rsp_data_in  = {{RSP_PAD_W{1'b0}}, cause_out, DEPTH_W'(depth_in), top_in, rule_out};
      rsp_valid_in = emit | (rsp_valid_ff & !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= DW'(1);
         top_ff       <= '0;
         status_ff    <= PS_RUNNING;
         red_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         top_ff       <= top_in;
         status_ff    <= status_in;
         red_cnt_ff   <= red_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_comb begin
      stat.running    = status_ff == PS_RUNNING;
      stat.act_code   = act_code;
      stat.act_oob    = int'(top_ff) >= STATES || int'(tok_ff) >= SYMBOLS;
      stat.tgt_bad    = int'(act_tgt) >= RULES;
      stat.red_limit  = red_cnt_ff == RED_LIMIT;
      stat.stack_full = int'(depth_ff) >= STACK_DEPTH;
      stat.len_under  = int'(rule_len) >= int'(depth_ff);
      stat.grow_full  = int'(nd_calc) >= STACK_DEPTH;
      stat.goto_ok    = act_code == CODE_GOTO && !goto_oob_ff;
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/lr_table_parser_engine.sv */
// ----------------------------------------------------------------------------
// lr_table_parser_engine
// Table-driven SLR shift-reduce parse engine.
//
// req_* carries load, start and token beats; req_tuser selects the kind.
// Entry and rule beats fill the action/goto table and rule store, a start
// beat puts the stack back to state 0. Load and start beats give no result.
// A token beat yields one rsp_* beat per reduction (rsp_tlast low), then one
// shift, accept or error beat with rsp_tlast high. Each reduction steps
// through entry read, rule read, stack read, goto read and update in turn,
// as the action table has a single read port for entry and goto reads.
// After accept or error, token beats are dropped until a start beat.
// The result register holds while rsp_tready is low; the engine stalls at its
// next result and takes no new beat until the token is done.
// Reset (synchronous) empties the stack to state 0 and sets running; table
// and rule contents are kept and must be written before use.
// ----------------------------------------------------------------------------
module lr_table_parser_engine
   import lrtp_pkg::*;
#(
   parameter int STATES      = 64,
   parameter int SYMBOLS     = 16,
   parameter int RULES       = 32,
   parameter int STACK_DEPTH = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row, column, entry_code, entry_target, rule_index, rule_head,
   // rule_length, token
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rule, state, depth, error_cause
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // event_res
   output logic [EV_W-1:0]       rsp_tuser,
   output logic                  rsp_tlast
);

   req_type  req;
   cmd_type  cmd;
   stat_type stat;

   always_comb begin
      req.kind         = kind_type'(req_tuser);
      req.row          = req_tdata[REQ_ROW_LSB  +: ROW_W];
      req.column       = req_tdata[REQ_COL_LSB  +: COL_W];
      req.entry_code   = req_tdata[REQ_CODE_LSB +: CODE_W];
      req.entry_target = req_tdata[REQ_TGT_LSB  +: TGT_W];
      req.rule_index   = req_tdata[REQ_RIDX_LSB +: RIDX_W];
      req.rule_head    = req_tdata[REQ_HEAD_LSB +: HEAD_W];
      req.rule_length  = req_tdata[REQ_LEN_LSB  +: LEN_W];
      req.token        = req_tdata[REQ_TOK_LSB  +: TOK_W];
   end

   lrtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req.kind),
      .stat       (stat),
      .cmd        (cmd)
   );

   lrtp_dpath #(
      .STATES      (STATES),
      .SYMBOLS     (SYMBOLS),
      .RULES       (RULES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hdl/lrtp_checker.sv */
// ----------------------------------------------------------------------------
// lrtp_checker
// Port-level checks on the result stream of the parse engine.
// ----------------------------------------------------------------------------
module lrtp_checker
   import lrtp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [KIND_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [EV_W-1:0]       rsp_tuser,
   input logic                  rsp_tlast
);

   logic [CAUSE_W-1:0] cause;
   logic [DEPTH_W-1:0] depth;
   logic [RULE_W-1:0]  rule;
   logic               req_beat;

   assign cause    = rsp_tdata[RSP_CAUSE_LSB +: CAUSE_W];
   assign depth    = rsp_tdata[RSP_DEPTH_LSB +: DEPTH_W];
   assign rule     = rsp_tdata[RSP_RULE_LSB +: RULE_W];
   assign req_beat = req_tvalid && req_tready && (req_tdata != '1 || req_tuser != '1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ERROR |-> rsp_tlast && cause != CAUSE_NONE)
      else $error("error beat without last or cause");

   a_reduce_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_REDUCE |-> !rsp_tlast && cause == CAUSE_NONE)
      else $error("reduce beat marked last or with cause");

   a_rule_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_REDUCE |-> rule == '0)
      else $error("rule set on a beat that is not a reduce");

   a_depth_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid || req_beat |-> depth != '0 || !rsp_tvalid)
      else $error("result beat with empty stack");

endmodule

bind lr_table_parser_engine lrtp_checker u_lrtp_checker (.*);

/* tb/sv/tb_lr_table_parser_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lr_table_parser_engine
// Self-checking bench for the SLR shift-reduce parse engine. The table rows of
// a small state set and the rules in use are loaded first, with a shaped
// random grammar that includes a reduce ladder climbing to a full stack. A
// short set of token runs then hits shift, accept, empty entries, bad rules,
// underflow, bad goto, the reduction limit and both kinds of overflow. Random
// parse runs follow that mostly pick tokens the current state can take. A
// predictor class tracks table, rules and stack per accepted beat and checks
// every response beat in order. Both sides idle at random; the receiver
// chokes once and the sender drains once.
// ----------------------------------------------------------------------------
module tb_lr_table_parser_engine;
   import lrtp_pkg::*;

   localparam int          RULE_COUNT   = 32;
   localparam int          STACK_SLOTS  = 64;
   localparam int          ROW_SPAN     = 4;
   localparam int          RULE_SPAN    = 8;
   localparam int          RANDOM_ITEMS = 40;
   localparam int          CHOKE_AT     = 10;
   localparam int          DRAIN_AT     = 28;
   localparam int          CHOKE_CYCLES = 600;
   localparam int unsigned LIMIT_CYCLES = 2_000_000;
   localparam int          START_MARK   = -1;

   localparam logic [COL_W-1:0]  LADDER_TOK  = 4'd9;
   localparam logic [COL_W-1:0]  LADDER_HEAD = 4'd10;
   localparam logic [TGT_W-1:0]  LADDER_RULE = 6'd31;

   typedef struct {
      ev_type               ev;
      logic [RULE_W-1:0]    rule;
      logic [STATE_W-1:0]   state;
      logic [DEPTH_W-1:0]   depth;
      cause_type            cause;
      logic                 last;
   } parse_event_t;

   class lr_parse_predictor;
      logic [CODE_W-1:0]  act_code [1024];
      logic [TGT_W-1:0]   act_tgt [1024];
      logic [HEAD_W-1:0]  rule_head [RULE_COUNT];
      logic [LEN_W-1:0]   rule_len [RULE_COUNT];
      logic [STATE_W-1:0] stack_st [STACK_SLOTS];
      int unsigned        depth;
      pstat_type          status;
      parse_event_t       expected_events [$];
      int                 mismatches;

      function new();
         stack_st[0] = '0;
         depth = 1;
         status = PS_RUNNING;
         mismatches = 0;
      endfunction

      function void post(ev_type ev, logic [RULE_W-1:0] rl, cause_type cs, logic lst);
         expected_events.push_back('{ev, rl, stack_st[depth-1], DEPTH_W'(depth), cs, lst});
      endfunction

      function void refuse(cause_type cs);
         post(EV_ERROR, '0, cs, 1'b1);
         status = PS_FAILED;
      endfunction

      // returns the number of response beats, or -1 for a dropped token
      function int note_beat(req_type r);
         int unsigned       idx;
         logic [CODE_W-1:0] code;
         logic [TGT_W-1:0]  tgt;
         logic [HEAD_W-1:0] head;
         logic [LEN_W-1:0]  len;
         int unsigned       nd;
         int unsigned       reds;
         int                n0;
         bit                done;
         if (r.kind == KIND_ENTRY) begin
            act_code[{r.row, r.column}] = r.entry_code;
            act_tgt[{r.row, r.column}] = r.entry_target;
            return 0;
         end
         if (r.kind == KIND_RULE) begin
            rule_head[r.rule_index] = r.rule_head;
            rule_len[r.rule_index] = r.rule_length;
            return 0;
         end
         if (r.kind == KIND_START) begin
            stack_st[0] = '0;
            depth = 1;
            status = PS_RUNNING;
            return 0;
         end
         if (status != PS_RUNNING) return -1;
         n0 = expected_events.size();
         reds = 0;
         done = 1'b0;
         while (!done) begin
            idx = {stack_st[depth-1], r.token};
            code = act_code[idx];
            tgt = act_tgt[idx];
            done = 1'b1;
            if (code == CODE_SHIFT) begin
               if (depth >= STACK_SLOTS) refuse(CAUSE_OVERFLOW);
               else begin
                  stack_st[depth] = tgt;
                  depth++;
                  post(EV_SHIFT, '0, CAUSE_NONE, 1'b1);
               end
            end else if (code == CODE_ACCEPT) begin
               post(EV_ACCEPT, '0, CAUSE_NONE, 1'b1);
               status = PS_ACCEPTED;
            end else if (code != CODE_REDUCE || tgt >= RULE_COUNT) begin
               refuse(CAUSE_EMPTY);
            end else if (reds >= RED_LIMIT) begin
               refuse(CAUSE_LIMIT);
            end else begin
               head = rule_head[tgt[RULE_W-1:0]];
               len = rule_len[tgt[RULE_W-1:0]];
               if (len >= depth) refuse(CAUSE_UNDERFLOW);
               else if (depth - len + 1 > STACK_SLOTS) refuse(CAUSE_OVERFLOW);
               else begin
                  nd = depth - len;
                  idx = {stack_st[nd-1], head};
                  if (act_code[idx] != CODE_GOTO) refuse(CAUSE_UNDERFLOW);
                  else begin
                     stack_st[nd] = act_tgt[idx];
                     depth = nd + 1;
                     post(EV_REDUCE, tgt[RULE_W-1:0], CAUSE_NONE, 1'b0);
                     reds++;
                     done = 1'b0;
                  end
               end
            end
         end
         return expected_events.size() - n0;
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("rsp %s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(logic [EV_W-1:0] ev, logic [RULE_W-1:0] rl,
                                logic [STATE_W-1:0] st, logic [DEPTH_W-1:0] dp,
                                logic [CAUSE_W-1:0] cs, logic lst);
         parse_event_t want;
         if (expected_events.size() == 0) begin
            $error("unexpected rsp beat: event %0d state %0d depth %0d", ev, st, dp);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         compare_field("event_res", 8'(want.ev), 8'(ev));
         compare_field("rule", 8'(want.rule), 8'(rl));
         compare_field("state", 8'(want.state), 8'(st));
         compare_field("depth", 8'(want.depth), 8'(dp));
         compare_field("error_cause", 8'(want.cause), 8'(cs));
         compare_field("last", 8'(want.last), 8'(lst));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [EV_W-1:0]       rsp_tuser;
   logic                  rsp_tlast;

   lr_parse_predictor board = new();
   int unsigned       cycles = 0;
   int                counted = 0;
   int                burst_left = 0;
   bit                choke_rsp = 1'b0;

   lr_table_parser_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_event(rsp_tuser, rsp_tdata[RSP_RULE_LSB +: RULE_W],
                           rsp_tdata[RSP_STATE_LSB +: STATE_W],
                           rsp_tdata[RSP_DEPTH_LSB +: DEPTH_W],
                           rsp_tdata[RSP_CAUSE_LSB +: CAUSE_W], rsp_tlast);
   end

   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type noise_beat(kind_type k);
      logic [63:0] raw;
      req_type     r;
      raw = {$urandom, $urandom};
      r = req_type'(raw[$bits(req_type)-1:0]);
      r.kind = k;
      return r;
   endfunction

   function automatic req_type entry_beat(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                          code_type code, logic [TGT_W-1:0] tgt);
      req_type r;
      r = noise_beat(KIND_ENTRY);
      r.row = row;
      r.column = col;
      r.entry_code = code;
      r.entry_target = tgt;
      return r;
   endfunction

   function automatic req_type rule_beat(logic [RIDX_W-1:0] idx, logic [HEAD_W-1:0] head,
                                         logic [LEN_W-1:0] len);
      req_type r;
      r = noise_beat(KIND_RULE);
      r.rule_index = idx;
      r.rule_head = head;
      r.rule_length = len;
      return r;
   endfunction

   function automatic req_type tok_beat(logic [TOK_W-1:0] t);
      req_type r;
      r = noise_beat(KIND_TOKEN);
      r.token = t;
      return r;
   endfunction

   // columns 0-8 act as terminals, 9/10 form the reduce ladder, 11-15 are gotos
   function automatic req_type shaped_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      int               p;
      logic [TGT_W-1:0] any_tgt;
      p = $urandom_range(0, 99);
      any_tgt = TGT_W'($urandom_range(0, ROW_SPAN - 1));
      if (col == LADDER_TOK)
         return (row == ROW_W'(ROW_SPAN - 1)) ? entry_beat(row, col, CODE_SHIFT, '0)
                                              : entry_beat(row, col, CODE_REDUCE, LADDER_RULE);
      if (col == LADDER_HEAD)
         return entry_beat(row, col, CODE_GOTO, TGT_W'((int'(row) + 1) % ROW_SPAN));
      if (col > LADDER_HEAD)
         return (p < 85) ? entry_beat(row, col, CODE_GOTO, any_tgt)
                         : entry_beat(row, col, code_type'($urandom_range(0, 3)), any_tgt);
      if (p < 45) return entry_beat(row, col, CODE_SHIFT, any_tgt);
      if (p < 78)
         return entry_beat(row, col, CODE_REDUCE, TGT_W'($urandom_range(0, RULE_SPAN - 1)));
      if (p < 82)
         return entry_beat(row, col, CODE_REDUCE, TGT_W'($urandom_range(RULE_COUNT, 63)));
      if (p < 86) return entry_beat(row, col, CODE_ACCEPT, any_tgt);
      if (p < 94) return entry_beat(row, col, CODE_EMPTY, any_tgt);
      return entry_beat(row, col, CODE_GOTO, any_tgt);
   endfunction

   function automatic req_type shaped_rule(logic [RIDX_W-1:0] idx);
      logic [HEAD_W-1:0] head;
      logic [LEN_W-1:0]  len;
      head = ($urandom_range(0, 99) < 80) ? HEAD_W'($urandom_range(10, 15))
                                          : HEAD_W'($urandom_range(0, 9));
      len = ($urandom_range(0, 99) < 75) ? LEN_W'($urandom_range(0, 3))
                                         : LEN_W'($urandom_range(0, 15));
      return rule_beat(idx, head, len);
   endfunction

   // favor tokens the top state can shift or reduce on
   function automatic req_type token_beat();
      logic [COL_W-1:0]   live [$];
      logic [STATE_W-1:0] top;
      top = board.stack_st[board.depth - 1];
      for (int c = 0; c < 16; c++)
         if (COL_W'(c) != LADDER_TOK &&
             board.act_code[{top, COL_W'(c)}] inside {CODE_SHIFT, CODE_REDUCE})
            live.push_back(COL_W'(c));
      if (live.size() != 0 && $urandom_range(0, 99) < 75)
         return tok_beat(live[$urandom_range(0, live.size() - 1)]);
      return tok_beat(TOK_W'($urandom_range(0, 15)));
   endfunction

   task automatic offer(input req_type r);
      logic [REQ_DATA_W-1:0] d;
      int                    n;
      n = (burst_left > 0) ? 0 : idle_len();
      if (burst_left > 0) burst_left--;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      d = '0;
      d[REQ_ROW_LSB +: ROW_W] = r.row;
      d[REQ_COL_LSB +: COL_W] = r.column;
      d[REQ_CODE_LSB +: CODE_W] = r.entry_code;
      d[REQ_TGT_LSB +: TGT_W] = r.entry_target;
      d[REQ_RIDX_LSB +: RIDX_W] = r.rule_index;
      d[REQ_HEAD_LSB +: HEAD_W] = r.rule_head;
      d[REQ_LEN_LSB +: LEN_W] = r.rule_length;
      d[REQ_TOK_LSB +: TOK_W] = r.token;
      req_tdata <= d;
      req_tuser <= r.kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (board.note_beat(r) >= 0) counted++;
   endtask

   initial begin : rsp_side
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (choke_rsp) begin
            rsp_tready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
            choke_rsp = 1'b0;
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin : req_side
      int drill [$];
      int p;
      bit choked;
      bit drained;
      drill = '{9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9,
                START_MARK, 0, 0, 0, START_MARK, 1, START_MARK, 2, START_MARK, 3,
                START_MARK, 4, START_MARK, 5, START_MARK, 6, 5};
      choked = 1'b0;
      drained = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < ROW_SPAN; row++)
         for (int col = 0; col < 16; col++)
            offer(shaped_entry(ROW_W'(row), COL_W'(col)));
      for (int i = 0; i < RULE_SPAN; i++)
         offer(shaped_rule(RIDX_W'(i)));
      offer(rule_beat(5'd31, LADDER_HEAD, 4'd0));
      offer(rule_beat(5'd0, 4'd15, 4'd1));
      offer(rule_beat(5'd1, 4'd15, 4'd15));
      offer(rule_beat(5'd2, 4'd4, 4'd0));
      offer(rule_beat(5'd3, 4'd14, 4'd0));
      offer(entry_beat(6'd0, 4'd0, CODE_SHIFT, 6'd3));
      offer(entry_beat(6'd3, 4'd0, CODE_REDUCE, 6'd0));
      offer(entry_beat(6'd0, 4'd15, CODE_GOTO, 6'd2));
      offer(entry_beat(6'd2, 4'd0, CODE_ACCEPT, 6'd0));
      offer(entry_beat(6'd0, 4'd1, CODE_EMPTY, 6'd0));
      offer(entry_beat(6'd0, 4'd2, CODE_REDUCE, 6'd40));
      offer(entry_beat(6'd0, 4'd3, CODE_REDUCE, 6'd1));
      offer(entry_beat(6'd0, 4'd4, CODE_REDUCE, 6'd2));
      offer(entry_beat(6'd0, 4'd5, CODE_REDUCE, 6'd3));
      offer(entry_beat(6'd0, 4'd14, CODE_GOTO, 6'd0));
      offer(entry_beat(6'd0, 4'd6, CODE_SHIFT, 6'd0));

      foreach (drill[i])
         offer(drill[i] == START_MARK ? noise_beat(KIND_START) : tok_beat(TOK_W'(drill[i])));

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (!choked && counted >= CHOKE_AT) begin
            choke_rsp = 1'b1;
            choked = 1'b1;
         end
         if (!drained && counted >= DRAIN_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (board.expected_events.size() != 0);
            drained = 1'b1;
         end
         if (burst_left == 0 && $urandom_range(0, 99) < 4) burst_left = $urandom_range(10, 30);
         p = $urandom_range(0, 99);
         if (board.status != PS_RUNNING)
            offer(p < 85 ? noise_beat(KIND_START) : token_beat());
         else if (p < 8)
            offer(shaped_entry(ROW_W'($urandom_range(0, ROW_SPAN - 1)),
                               COL_W'($urandom_range(0, 15))));
         else if (p < 12)
            offer(shaped_rule(RIDX_W'($urandom_range(0, RULE_SPAN - 1))));
         else if (p < 15)
            offer(noise_beat(KIND_START));
         else
            offer(token_beat());
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.expected_events.size() != 0);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
